### hw/rtl/mbma_pkg.sv
// ----------------------------------------------------------------------------
// mbma_pkg: shared types and constants
// Request payload types, configuration indexes and helper widths.
// ----------------------------------------------------------------------------
`default_nettype none
package mbma_pkg;
    localparam int MaxWidthDef  = 256;
    localparam int MaxHeightDef = 256;
    localparam int HeatBits     = 24;
    localparam int CoordBits    = 12;
    localparam int DimBits      = 7;
    localparam int OrgBits      = 11;
    localparam int SizeBits     = 9;
    localparam int CfgIdxBits   = 3;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_BLOCK_DIM    = 3'd0,
        CFG_MAP_ORIGIN_X = 3'd1,
        CFG_MAP_ORIGIN_Y = 3'd2,
        CFG_MAP_WIDTH    = 3'd3,
        CFG_MAP_HEIGHT   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [HeatBits-1:0] cell_heat;
        logic                       cell_enabled;
        logic                       map_start;
    } cell_req_t;

    typedef struct packed {
        logic                        block_found;
        logic [CoordBits-1:0]        block_x;
        logic [CoordBits-1:0]        block_y;
        logic [DimBits-1:0]          block_w;
        logic [DimBits-1:0]          block_h;
        logic signed [HeatBits-1:0]  peak_heat;
        logic [CoordBits-1:0]        peak_x;
        logic [CoordBits-1:0]        peak_y;
        logic                        map_done;
        logic                        best_found;
        logic [CoordBits-1:0]        best_x;
        logic [CoordBits-1:0]        best_y;
    } block_res_t;

    // Classified cell handed from front to back.
    typedef struct packed {
        logic signed [HeatBits-1:0] heat;
        logic                       en;
        logic                       restart;   // overall best restarts first
        logic                       blk_first; // first cell of its block
        logic                       blk_last;  // last cell of its block
        logic                       map_end;
        logic [CoordBits-1:0]       col;
        logic [CoordBits-1:0]       row;
        logic [CoordBits-1:0]       bc;
        logic [CoordBits-1:0]       br;
        logic [DimBits-1:0]         bw;
        logic [DimBits-1:0]         bh;
    } cell_cls_t;

    // One entry of the per-block-column peak store.
    typedef struct packed {
        logic                       found;
        logic signed [HeatBits-1:0] heat;
        logic [CoordBits-1:0]       px;
        logic [CoordBits-1:0]       py;
    } peak_ent_t;
endpackage
`default_nettype wire

### hw/rtl/mbma_front.sv
// ----------------------------------------------------------------------------
// mbma_front: scan position tracking
// Walks the raster position, marks block boundaries and clipped sizes.
// ----------------------------------------------------------------------------
`default_nettype none
module mbma_front #(
    parameter int MAX_WIDTH  = mbma_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = mbma_pkg::MaxHeightDef
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_restart,
    input  wire logic [mbma_pkg::DimBits-1:0]   dim,
    input  wire logic [mbma_pkg::SizeBits-1:0]  width_raw,
    input  wire logic [mbma_pkg::SizeBits-1:0]  height_raw,
    input  wire logic                           in_valid,
    input  wire mbma_pkg::cell_req_t            in_req,
    input  wire logic                           take,
    output mbma_pkg::cell_cls_t                 cls
);
    import mbma_pkg::*;
    logic [CoordBits-1:0] col_reg, col_next, row_reg, row_next;
    logic [5:0] wc_reg, wc_next, wr_reg, wr_next;
    logic [DimBits-1:0] d;
    logic [CoordBits-1:0] w, h, col, row, bw, bh;
    logic [5:0] wc, wr;
    logic restart, lc, lr, col_end, row_end;

    always_comb
    begin
        d = (dim == '0) ? DimBits'(1) : (dim > DimBits'(64) ? DimBits'(64) : dim);
        w = (width_raw == '0) ? CoordBits'(1)
            : ((int'(width_raw) > MAX_WIDTH) ? CoordBits'(MAX_WIDTH)
               : CoordBits'(width_raw));
        h = (height_raw == '0) ? CoordBits'(1)
            : ((int'(height_raw) > MAX_HEIGHT) ? CoordBits'(MAX_HEIGHT)
               : CoordBits'(height_raw));
        restart = in_req.map_start || col_reg >= w || row_reg >= h
                  || 7'(wc_reg) >= d || 7'(wr_reg) >= d;
        col = restart ? '0 : col_reg;
        row = restart ? '0 : row_reg;
        wc  = restart ? '0 : wc_reg;
        wr  = restart ? '0 : wr_reg;
        col_end = (col == w - 1'b1);
        row_end = (row == h - 1'b1);
        lc = (7'(wc) == d - 1'b1) || col_end;
        lr = (7'(wr) == d - 1'b1) || row_end;
        cls.heat      = in_req.cell_heat;
        cls.en        = in_req.cell_enabled;
        cls.restart   = restart;
        cls.blk_first = (wc == '0) && (wr == '0);
        cls.blk_last  = lc && lr;
        cls.map_end   = col_end && row_end;
        cls.col       = col;
        cls.row       = row;
        cls.bc        = col - CoordBits'(wc);
        cls.br        = row - CoordBits'(wr);
        bw = w - cls.bc;
        bh = h - cls.br;
        cls.bw = (bw > CoordBits'(d)) ? d : DimBits'(bw);
        cls.bh = (bh > CoordBits'(d)) ? d : DimBits'(bh);
        col_next = col_reg; row_next = row_reg; wc_next = wc_reg; wr_next = wr_reg;
        if (cfg_restart)
        begin
            col_next = '0; row_next = '0; wc_next = '0; wr_next = '0;
        end
        else if (in_valid && take)
        begin
            if (cls.map_end)
            begin
                col_next = '0; row_next = '0; wc_next = '0; wr_next = '0;
            end
            else if (col_end)
            begin
                col_next = '0; wc_next = '0;
                row_next = row + 1'b1;
                wr_next = (7'(wr) == d - 1'b1) ? '0 : wr + 1'b1;
            end
            else
            begin
                col_next = col + 1'b1;
                row_next = row;
                wr_next = wr;
                wc_next = (7'(wc) == d - 1'b1) ? '0 : wc + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0; row_reg <= '0; wc_reg <= '0; wr_reg <= '0;
        end
        else
        begin
            col_reg <= col_next; row_reg <= row_next;
            wc_reg <= wc_next; wr_reg <= wr_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mbma_fifo.sv
// ----------------------------------------------------------------------------
// mbma_fifo: two-entry queue
// Decouples the front scan from the back accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module mbma_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire mbma_pkg::cell_cls_t  push_data,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output mbma_pkg::cell_cls_t       head
);
    import mbma_pkg::*;
    cell_cls_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg[1];
    assign not_empty = cnt_reg != 2'd0;
    assign head = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mbma_back.sv
// ----------------------------------------------------------------------------
// mbma_back: block peak accumulator
// Per-column-block peak store, overall best and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module mbma_back #(
    parameter int MAX_WIDTH = mbma_pkg::MaxWidthDef
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_restart,
    input  wire logic [mbma_pkg::DimBits-1:0]  dim,
    input  wire logic [mbma_pkg::OrgBits-1:0]  org_x,
    input  wire logic [mbma_pkg::OrgBits-1:0]  org_y,
    input  wire logic                          cell_valid,
    input  wire mbma_pkg::cell_cls_t           cls_in,
    output logic                               cell_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mbma_pkg::block_res_t               out_res
);
    import mbma_pkg::*;
    // Block column index = running count, kept per scan position.
    localparam int NB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // Peak store, one entry per block column; a block stays open across its
    // rows. An entry is rewritten at its block's first cell before use.
    peak_ent_t                   peak_mem [MAX_WIDTH];
    peak_ent_t                   rd_reg, byp_data_reg, old, wr_ent;
    logic                        byp_reg;
    logic                        s1_v_reg;
    cell_cls_t                   s1_reg;
    logic [NB-1:0]               s1_idx_reg;
    logic [NB-1:0]               idx_reg, idx;
    logic signed [HeatBits-1:0]  gh_reg;
    logic                        gf_reg;
    logic [CoordBits-1:0]        gx_reg, gy_reg;
    logic [NB-1:0]               gb_reg;
    logic                        ov_reg;
    block_res_t                  res_reg;
    logic [DimBits-1:0]          d;
    logic                        fire, res_due, found_old, take, found;
    logic signed [HeatBits-1:0]  bh_v;
    logic [CoordBits-1:0]        bx_v, by_v, gx_v, gy_v;
    logic                        gf_v, gtake;
    logic signed [HeatBits-1:0]  gh_v;
    logic [NB-1:0]               gb_v;

    assign d = (dim == '0) ? DimBits'(1) : (dim > DimBits'(64) ? DimBits'(64) : dim);
    // stage 1 holds the cell whose store entry has been read
    assign fire = s1_v_reg && (!ov_reg || !out_stall);
    assign cell_pop = cell_valid && (!s1_v_reg || fire);
    assign out_valid = ov_reg;
    assign out_res = res_reg;
    // Block column index tracked incrementally alongside the column.
    assign idx = (cls_in.col == '0) ? '0 : idx_reg;

    always_comb
    begin
        // entry written by the previous cell at the read edge is bypassed
        old = byp_reg ? byp_data_reg : rd_reg;
        found_old = old.found && !s1_reg.blk_first;
        take = s1_reg.en && (!found_old || s1_reg.heat > old.heat
                             || (s1_reg.heat == old.heat && s1_reg.col < old.px));
        found = found_old || take;
        bh_v = take ? s1_reg.heat : old.heat;
        bx_v = take ? s1_reg.col : old.px;
        by_v = take ? s1_reg.row : old.py;
        wr_ent.found = found;
        wr_ent.heat = bh_v;
        wr_ent.px = bx_v;
        wr_ent.py = by_v;
        res_due = s1_reg.blk_last && (found || s1_reg.map_end);
        gh_v = s1_reg.restart ? {1'b1, {(HeatBits-1){1'b0}}} : gh_reg;
        gf_v = s1_reg.restart ? 1'b0 : gf_reg;
        gx_v = s1_reg.restart ? '0 : gx_reg;
        gy_v = s1_reg.restart ? '0 : gy_reg;
        gb_v = s1_reg.restart ? '0 : gb_reg;
        gtake = s1_reg.blk_last && found
                && (!gf_v || bh_v > gh_v || (bh_v == gh_v && s1_idx_reg < gb_v));
        if (gtake)
        begin
            gh_v = bh_v; gf_v = 1'b1; gx_v = bx_v; gy_v = by_v; gb_v = s1_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            peak_mem[s1_idx_reg] <= wr_ent;
        end
        if (cell_pop)
        begin
            rd_reg <= peak_mem[idx];
            byp_data_reg <= wr_ent;
            s1_reg <= cls_in;
        end
        if (fire && res_due)
        begin
            res_reg.block_found <= found;
            res_reg.block_x <= CoordBits'(org_x) + s1_reg.bc;
            res_reg.block_y <= CoordBits'(org_y) + s1_reg.br;
            res_reg.block_w <= s1_reg.bw;
            res_reg.block_h <= s1_reg.bh;
            res_reg.peak_heat <= found ? bh_v : '0;
            res_reg.peak_x <= found ? CoordBits'(org_x) + bx_v : '0;
            res_reg.peak_y <= found ? CoordBits'(org_y) + by_v : '0;
            res_reg.map_done <= s1_reg.map_end;
            res_reg.best_found <= s1_reg.map_end && gf_v;
            res_reg.best_x <= (s1_reg.map_end && gf_v) ? CoordBits'(org_x) + gx_v : '0;
            res_reg.best_y <= (s1_reg.map_end && gf_v) ? CoordBits'(org_y) + gy_v : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0; s1_v_reg <= 1'b0; s1_idx_reg <= '0; idx_reg <= '0;
            gh_reg <= {1'b1, {(HeatBits-1){1'b0}}};
            gf_reg <= 1'b0; gx_reg <= '0; gy_reg <= '0; gb_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= (ov_reg && out_stall) || (fire && res_due);
            if (cell_pop)
            begin
                s1_v_reg <= 1'b1;
                s1_idx_reg <= idx;
                byp_reg <= fire && (s1_idx_reg == idx);
                // next column's block index
                if (cls_in.col == cls_in.bc + CoordBits'(d) - 1'b1)
                    idx_reg <= (idx == NB'(MAX_WIDTH - 1)) ? idx : idx + 1'b1;
                else
                    idx_reg <= idx;
            end
            else if (fire)
            begin
                s1_v_reg <= 1'b0;
            end
            if (fire)
            begin
                if (s1_reg.map_end)
                begin
                    gh_reg <= {1'b1, {(HeatBits-1){1'b0}}};
                    gf_reg <= 1'b0; gx_reg <= '0; gy_reg <= '0; gb_reg <= '0;
                end
                else
                begin
                    gh_reg <= gh_v; gf_reg <= gf_v; gx_reg <= gx_v;
                    gy_reg <= gy_v; gb_reg <= gb_v;
                end
            end
            else if (cfg_restart)
            begin
                gh_reg <= {1'b1, {(HeatBits-1){1'b0}}};
                gf_reg <= 1'b0; gx_reg <= '0; gy_reg <= '0; gb_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/masked_block_max_argmax.sv
// ----------------------------------------------------------------------------
// masked_block_max_argmax: masked block max pooling with argmax
// Streams map cells, reports each block's hottest enabled cell and the
// overall hottest block at the end of the map.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall/in_data, one cell per request in raster
//   order. Results leave on out_valid/out_stall/out_data, at most one per cell,
//   on the last cell of a block that had an enabled cell, and always on the
//   map's last cell (which also carries the overall best).
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data while idle;
//   any write to index 0 to 4 restarts the scan and the overall best.
//   Throughput: one cell per clock while no stalled result blocks it, set by
//   the single compare-and-update of the block peak store in the back end.
//   Path from accepted cell to result: the front classifies into a two-entry
//   queue; the back end pops it into the store read stage, then updates the
//   store and registers the result.
//   Reset clears scan counters and the overall best; the peak store, found
//   flags included, is not cleared and each entry is rewritten at its
//   block's first cell before it is used.
//   When out_stall holds, the result register holds, the read stage and the
//   queue fill and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none
module masked_block_max_argmax #(
    parameter int MAX_WIDTH  = mbma_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = mbma_pkg::MaxHeightDef
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire mbma_pkg::cell_req_t              in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output mbma_pkg::block_res_t                  out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mbma_pkg::CfgIdxBits-1:0]  cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import mbma_pkg::*;
    logic [DimBits-1:0]  dim_reg;
    logic [OrgBits-1:0]  ox_reg, oy_reg;
    logic [SizeBits-1:0] w_reg, h_reg;
    logic                cfg_wr, cfg_hit, full, ne, pop, push;
    cell_cls_t           cls, head;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;
    assign cfg_hit = cfg_wr && (cfg_index <= CfgIdxBits'(CFG_MAP_HEIGHT));
    assign in_stall = full;
    assign push = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DimBits'(8); ox_reg <= '0; oy_reg <= '0;
            w_reg <= SizeBits'(256); h_reg <= SizeBits'(256);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BLOCK_DIM:    dim_reg <= cfg_data[DimBits-1:0];
                CFG_MAP_ORIGIN_X: ox_reg  <= cfg_data[OrgBits-1:0];
                CFG_MAP_ORIGIN_Y: oy_reg  <= cfg_data[OrgBits-1:0];
                CFG_MAP_WIDTH:    w_reg   <= cfg_data[SizeBits-1:0];
                CFG_MAP_HEIGHT:   h_reg   <= cfg_data[SizeBits-1:0];
                default: ;
            endcase
        end
    end

    mbma_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_restart(cfg_hit), .dim(dim_reg),
        .width_raw(w_reg), .height_raw(h_reg), .in_valid(in_valid),
        .in_req(in_data), .take(!full), .cls(cls)
    );

    mbma_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(cls), .pop(pop),
        .full(full), .not_empty(ne), .head(head)
    );

    mbma_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_restart(cfg_hit), .dim(dim_reg),
        .org_x(ox_reg), .org_y(oy_reg), .cell_valid(ne), .cls_in(head),
        .cell_pop(pop), .out_valid(out_valid), .out_stall(out_stall),
        .out_res(out_data)
    );
endmodule
`default_nettype wire

### hw/rtl/mbma_checker.sv
// ----------------------------------------------------------------------------
// mbma_checker: port-level checks
// Watches the top level's channels over time.
// ----------------------------------------------------------------------------
`default_nettype none
module mbma_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire mbma_pkg::block_res_t out_data,
    input wire logic                 in_valid,
    input wire logic                 in_stall
);
    import mbma_pkg::*;
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_best: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.map_done |-> !out_data.best_found)
        else $error("best outside map end");
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.block_found |-> out_data.map_done)
        else $error("empty block result not at map end");
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.block_w != '0 && out_data.block_h != '0)
        else $error("zero block size");
endmodule
bind masked_block_max_argmax mbma_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .in_valid(in_valid), .in_stall(in_stall)
);
`default_nettype wire
